// File: sv/decaying_sine_voice_mixer_assert.svh
// ---------------------------------------------------------------------------
// decaying sine voice mixer assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef DECAYING_SINE_VOICE_MIXER_ASSERT_SVH
`define DECAYING_SINE_VOICE_MIXER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DSVM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DSVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dsvm_pkg.sv
// ---------------------------------------------------------------------------
// dsvm_pkg
// types, codes, constants, the sine table generator and the mix saturation of the voice mixer
// ---------------------------------------------------------------------------
`default_nettype none

package dsvm_pkg;

    // input frame and result frame
    typedef struct packed {
        logic signed [15:0] in_left;
        logic signed [15:0] in_right;
        logic               restart;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               tone_active;
        logic               tone_last;
    } result_t;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_INCREMENT = 3'd0,
        CFG_DECAY_FACTOR    = 3'd1,
        CFG_TONE_GAIN       = 3'd2,
        CFG_PAN_LEFT_GAIN   = 3'd3,
        CFG_PAN_RIGHT_GAIN  = 3'd4,
        CFG_START_FRAME     = 3'd5,
        CFG_TONE_LENGTH     = 3'd6
    } cfg_reg_t;

    // register reset values
    localparam logic [24:0] ENV_ONE       = 25'd16777216;
    localparam logic [14:0] PAN_GAIN_INIT = 15'd23170;

    // output saturation limit, 0.95 in q1.15
    localparam logic signed [15:0] MIX_LIMIT = 16'sd31129;

    // fixed point constants for the sine table
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_ENV,
        ST_MUL_GAIN,
        ST_MUL_PAN_L,
        ST_MUL_PAN_R,
        ST_MUL_DECAY,
        ST_FINISH
    } state_t;

    // operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_ENV,
        MUL_GAIN,
        MUL_PAN_L,
        MUL_PAN_R,
        MUL_DECAY
    } mul_op_t;

    // controller to datapath
    typedef struct packed {
        logic    load_sample;
        logic    eval;
        mul_op_t mul_op;
        logic    finish;
    } dsvm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tone_active;
        logic result_busy;
    } dsvm_status_t;

    // quarter-wave sine entry k for a table of 2^log2_depth steps,
    // odd taylor series through x^11 in q30, horner with truncation
    function automatic logic [14:0] sine_entry(input int unsigned k,
                                               input int unsigned log2_depth);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned e;
        x  = (longint'(k) * Q30_HALF_PI) >> log2_depth;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        e  = (s + 64'd16384) >> 15;
        if (e > 64'd32767)
        begin
            e = 64'd32767;
        end
        return e[14:0];
    endfunction

    // clamp a channel sum to the mix limit
    function automatic logic signed [15:0] sat_mix(input logic signed [17:0] v);
        logic signed [17:0] lim;
        lim = 18'(MIX_LIMIT);
        if (v > lim)
        begin
            return MIX_LIMIT;
        end
        else if (v < -lim)
        begin
            return -MIX_LIMIT;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/dsvm_ctrl.sv
// ---------------------------------------------------------------------------
// dsvm_ctrl
// sequencer for one frame: window check, five products on the shared
// multiplier inside the tone window only, then the result transfer
// ---------------------------------------------------------------------------
`default_nettype none

module dsvm_ctrl
    import dsvm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         sample_valid,
    output logic              sample_stall,
    input  wire dsvm_status_t status,
    output dsvm_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd.load_sample = 1'b0;
        cmd.eval        = 1'b0;
        cmd.mul_op      = MUL_HOLD;
        cmd.finish      = 1'b0;
        sample_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.tone_active ? ST_MUL_ENV : ST_FINISH;
            end
            ST_MUL_ENV:
            begin
                cmd.mul_op = MUL_ENV;
                state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_op = MUL_GAIN;
                state_next = ST_MUL_PAN_L;
            end
            ST_MUL_PAN_L:
            begin
                cmd.mul_op = MUL_PAN_L;
                state_next = ST_MUL_PAN_R;
            end
            ST_MUL_PAN_R:
            begin
                cmd.mul_op = MUL_PAN_R;
                state_next = ST_MUL_DECAY;
            end
            ST_MUL_DECAY:
            begin
                cmd.mul_op = MUL_DECAY;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait until the output register is free
                if (!status.result_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/dsvm_datapath.sv
// ---------------------------------------------------------------------------
// dsvm_datapath
// configuration registers, voice state, sine rom, shared multiplier,
// channel mixing and the output register
// ---------------------------------------------------------------------------
`default_nettype none

module dsvm_datapath
    import dsvm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRAME_COUNT_BITS = 20
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire sample_t                sample,
    output result_t                     result,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    input  wire dsvm_cmd_t              cmd,
    output dsvm_status_t                status
);

    // table depth must be a power of two
    localparam int TABLE_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W      = TABLE_BITS + 1;
    localparam int FC_W       = FRAME_COUNT_BITS + 1;

    // configuration registers
    logic [30:0]                 phase_inc_reg;
    logic [24:0]                 decay_reg;
    logic [14:0]                 gain_reg;
    logic [14:0]                 pan_l_reg;
    logic [14:0]                 pan_r_reg;
    logic [FRAME_COUNT_BITS-1:0] start_reg;
    logic [FRAME_COUNT_BITS-1:0] length_reg;

    // voice state
    logic [FC_W-1:0] frame_reg;
    logic [31:0]     phase_reg;
    logic [24:0]     env_reg;

    // per-frame working registers
    logic signed [15:0] in_l_reg;
    logic signed [15:0] in_r_reg;
    logic               active_reg;
    logic               last_reg;
    logic               neg_reg;
    logic [14:0]        rom_q_reg;
    logic [49:0]        prod_reg;
    logic [14:0]        mag_reg;
    logic [14:0]        tone_l_reg;
    logic [14:0]        tone_r_reg;
    result_t            result_reg;
    logic               result_valid_reg;

    // quarter-wave sine rom, built at elaboration
    logic [14:0] sine_rom [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k, TABLE_BITS);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= '0;
            decay_reg     <= ENV_ONE;
            gain_reg      <= '0;
            pan_l_reg     <= PAN_GAIN_INIT;
            pan_r_reg     <= PAN_GAIN_INIT;
            start_reg     <= '0;
            length_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PHASE_INCREMENT: phase_inc_reg <= cfg_data[30:0];
                CFG_DECAY_FACTOR:    decay_reg     <= cfg_data[24:0];
                CFG_TONE_GAIN:       gain_reg      <= cfg_data[14:0];
                CFG_PAN_LEFT_GAIN:   pan_l_reg     <= cfg_data[14:0];
                CFG_PAN_RIGHT_GAIN:  pan_r_reg     <= cfg_data[14:0];
                CFG_START_FRAME:     start_reg     <= cfg_data[FRAME_COUNT_BITS-1:0];
                CFG_TONE_LENGTH:     length_reg    <= cfg_data[FRAME_COUNT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // tone window check on the current frame count
    logic [FC_W-1:0] start_w;
    logic [FC_W-1:0] end_w;
    logic            active_now;
    logic            last_now;

    assign start_w    = {1'b0, start_reg};
    assign end_w      = start_w + {1'b0, length_reg};
    assign active_now = (frame_reg >= start_w) && (frame_reg < end_w);
    assign last_now   = active_now && (frame_reg == end_w - FC_W'(1));

    // rom address from the phase, mirrored in the odd quadrants
    logic [TABLE_BITS-1:0] phase_idx;
    logic [IDX_W-1:0]      rom_addr;

    assign phase_idx = phase_reg[29 -: TABLE_BITS];
    assign rom_addr  = phase_reg[30] ? (IDX_W'(SINE_TABLE_DEPTH) - {1'b0, phase_idx})
                                     : {1'b0, phase_idx};

    // shared multiplier operand select
    logic [24:0] mul_a;
    logic [24:0] mul_b;
    logic [49:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_ENV:
            begin
                mul_a = {10'd0, rom_q_reg};
                mul_b = env_reg;
            end
            MUL_GAIN:
            begin
                mul_a = {10'd0, prod_reg[38:24]};
                mul_b = {10'd0, gain_reg};
            end
            MUL_PAN_L:
            begin
                mul_a = {10'd0, prod_reg[29:15]};
                mul_b = {10'd0, pan_l_reg};
            end
            MUL_PAN_R:
            begin
                mul_a = {10'd0, mag_reg};
                mul_b = {10'd0, pan_r_reg};
            end
            MUL_DECAY:
            begin
                mul_a = env_reg;
                mul_b = decay_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product register and magnitude captures
    always_ff @(posedge clk)
    begin
        if (cmd.mul_op != MUL_HOLD)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_op == MUL_PAN_L)
        begin
            mag_reg <= prod_reg[29:15];
        end
        if (cmd.mul_op == MUL_PAN_R)
        begin
            tone_l_reg <= prod_reg[29:15];
        end
        if (cmd.mul_op == MUL_DECAY)
        begin
            tone_r_reg <= prod_reg[29:15];
        end
    end

    // frame capture and window evaluation
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            in_l_reg <= sample.in_left;
            in_r_reg <= sample.in_right;
        end
        if (cmd.eval)
        begin
            active_reg <= active_now;
            last_reg   <= last_now;
            neg_reg    <= phase_reg[31];
            rom_q_reg  <= sine_rom[rom_addr];
        end
    end

    // decayed envelope, capped at one
    logic [25:0] env_prod;
    logic [24:0] env_decayed;

    assign env_prod    = prod_reg[49:24];
    assign env_decayed = (env_prod > {1'b0, ENV_ONE}) ? ENV_ONE : env_prod[24:0];

    // voice state: restart, advance during the tone, frame count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            phase_reg <= '0;
            env_reg   <= ENV_ONE;
        end
        else if (cmd.load_sample)
        begin
            if (sample.restart)
            begin
                frame_reg <= '0;
                phase_reg <= '0;
                env_reg   <= ENV_ONE;
            end
        end
        else if (cmd.finish)
        begin
            if (frame_reg != {FC_W{1'b1}})
            begin
                frame_reg <= frame_reg + FC_W'(1);
            end
            if (active_reg)
            begin
                phase_reg <= phase_reg + {1'b0, phase_inc_reg};
                env_reg   <= env_decayed;
            end
        end
    end

    // channel sums with saturation
    logic signed [17:0] tone_l_s;
    logic signed [17:0] tone_r_s;
    logic signed [17:0] sum_l;
    logic signed [17:0] sum_r;

    assign tone_l_s = active_reg ? $signed({3'b000, tone_l_reg}) : 18'sd0;
    assign tone_r_s = active_reg ? $signed({3'b000, tone_r_reg}) : 18'sd0;
    assign sum_l    = neg_reg ? (18'(in_l_reg) - tone_l_s) : (18'(in_l_reg) + tone_l_s);
    assign sum_r    = neg_reg ? (18'(in_r_reg) - tone_r_s) : (18'(in_r_reg) + tone_r_s);

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.out_left    <= sat_mix(sum_l);
            result_reg.out_right   <= sat_mix(sum_r);
            result_reg.tone_active <= active_reg;
            result_reg.tone_last   <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result               = result_reg;
    assign result_valid         = result_valid_reg;
    assign status.tone_active   = active_now;
    assign status.result_busy   = result_valid_reg && result_stall;

endmodule

`default_nettype wire

// File: sv/decaying_sine_voice_mixer.sv
// ---------------------------------------------------------------------------
// decaying_sine_voice_mixer: a frame goes through the window check, the five products
// (inside the tone window only) and the result transfer; result stalls hold the transfer
// one frame in flight; products on the shared multiplier; next frame taken after the transfer
// async reset: default registers, frame count and phase 0, envelope 1.0, no result
// ---------------------------------------------------------------------------
`default_nettype none

module decaying_sine_voice_mixer
    import dsvm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRAME_COUNT_BITS = 20
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   sample_valid,
    output logic                        sample_stall,
    input  wire sample_t                sample,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output result_t                     result
);

    dsvm_cmd_t    cmd;
    dsvm_status_t status;

    // registers take writes at any time
    assign cfg_ready = 1'b1;

    // frame sequencer
    dsvm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // arithmetic and storage
    dsvm_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// File: sv/dsvm_checker.sv
// ---------------------------------------------------------------------------
// dsvm_checker
// port level checks of the voice mixer, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "decaying_sine_voice_mixer_assert.svh"

module dsvm_checker
    import dsvm_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    sample_valid,
    input wire logic    sample_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // mixed samples stay inside the saturation limit
    `DSVM_ASSERT_NOW(a_range, result_valid, (result.out_left <= MIX_LIMIT) && (result.out_left >= -MIX_LIMIT) && (result.out_right <= MIX_LIMIT) && (result.out_right >= -MIX_LIMIT), "mix sample beyond limit")

    // last frame flag only inside the tone window
    `DSVM_ASSERT_NOW(a_last_in_window, result_valid && result.tone_last, result.tone_active, "tone_last outside window")

    // a frame transfer occupies the block for the next cycle
    `DSVM_ASSERT_NEXT(a_busy_after_transfer, sample_valid && !sample_stall, sample_stall, "frame taken while busy")

    // a stalled result holds
    `DSVM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind decaying_sine_voice_mixer dsvm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
